/* hw/rtl/lot_pkg.sv */
// Shared constants, types and helpers for the LRU order tracker.
package lot_pkg;

  // Number of key cells in the recency chain.
  localparam int ENTRIES  = 16;
  // Stored key width; input keys are sign-extended or truncated to it.
  localparam int KEY_BITS = 32;
  // Port widths fixed by the interface.
  localparam int IN_KEY_W = 32;
  localparam int OCC_W    = 5;
  // Internal widths derived from the depth.
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int IDX_W    = $clog2(ENTRIES);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [IDX_W-1:0]    idx_t;

  // Operation codes carried with each input word.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_EVICT  = 2'd1,
    OP_ACCESS = 2'd2,
    OP_PROBE  = 2'd3
  } opcode_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic shift;     // load the key from the more recent neighbor
    logic occupied;  // this cell lies below the held count
  } cell_ctl_t;

  // Bring a 32-bit signed input key to the stored key width.
  function automatic key_t widen_key(input logic signed [IN_KEY_W-1:0] raw);
    widen_key = KEY_BITS'(raw);
  endfunction

endpackage

/* hw/rtl/lru_order_tracker.sv */
// Top level of the LRU order tracker: a chain of key cells and the list control.
//
// Keeps up to 16 keys in recency order, most recent in cell 0. Each input
// word carries an opcode and a key: insert pushes the key at the recent
// end (refused with ok=0 when full), evict pops the least recent key and
// returns it in evicted_key (ok=0 when empty), access moves the first
// matching key to the recent end, and probe only reports a match.
// Every input word yields exactly one output word with ok, evicted_key and
// the occupancy after the operation.
// Both channels use valid/ready. A word is handled in the cycle it is
// accepted: all cells compare against the key in parallel, a priority
// chain through the cells picks the first match, and the cells shift in
// the same edge. The result appears in the output register in the cycle
// after acceptance; one word per cycle is sustained while the receiver
// takes results. When the receiver stalls, the held result stays and
// in_ready drops until it is taken. Reset empties the list and drops
// out_valid; the result fields and the cell contents are not cleared.
module lru_order_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic signed [lot_pkg::IN_KEY_W-1:0] key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic signed [lot_pkg::IN_KEY_W-1:0] evicted_key,
  output logic [lot_pkg::OCC_W-1:0]     occupancy
);
  import lot_pkg::*;

  cnt_t      count;
  cnt_t      count_next;
  key_t      key_in;
  key_t      cell_key [ENTRIES];
  logic      found [ENTRIES+1];
  cell_ctl_t ctl [ENTRIES];
  logic      take;
  logic      full;
  logic      empty;
  logic      hit;
  logic      shift_all;
  logic      shift_hit;
  logic      ok_next;
  logic signed [IN_KEY_W-1:0] ev_next;
  idx_t      tail;
  opcode_t   op;

  assign key_in   = widen_key(key);
  assign op       = opcode_t'(opcode);
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign full     = (count == CNT_W'(ENTRIES));
  assign empty    = (count == '0);
  assign hit      = found[ENTRIES];
  assign tail     = IDX_W'(count - 1'b1);
  assign found[0] = 1'b0;

  // The chain of cells; cell 0 takes the incoming key.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    always_comb begin
      ctl[i].occupied = (CNT_W'(i) < count);
      ctl[i].shift    = take && (shift_all || (shift_hit && !found[i]));
    end

    if (i == 0) begin : g_head
      lot_cell u_cell (
        .clk      (clk),
        .ctl      (ctl[i]),
        .key_left (key_in),
        .key_cmp  (key_in),
        .found_in (found[i]),
        .key_q    (cell_key[i]),
        .found_out(found[i+1])
      );
    end else begin : g_body
      lot_cell u_cell (
        .clk      (clk),
        .ctl      (ctl[i]),
        .key_left (cell_key[i-1]),
        .key_cmp  (key_in),
        .found_in (found[i]),
        .key_q    (cell_key[i]),
        .found_out(found[i+1])
      );
    end
  end

  // Decode the operation into shift controls, count update and result.
  always_comb begin
    shift_all  = 1'b0;
    shift_hit  = 1'b0;
    ok_next    = 1'b0;
    ev_next    = '0;
    count_next = count;
    unique case (op)
      OP_INSERT: begin
        if (!full) begin
          shift_all  = 1'b1;
          ok_next    = 1'b1;
          count_next = count + 1'b1;
        end
      end
      OP_EVICT: begin
        if (!empty) begin
          ok_next    = 1'b1;
          ev_next    = IN_KEY_W'(cell_key[tail]);
          count_next = count - 1'b1;
        end
      end
      OP_ACCESS: begin
        shift_hit = hit;
        ok_next   = hit;
      end
      OP_PROBE: begin
        ok_next = hit;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // Held count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (take) begin
      count <= count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ok          <= ok_next;
      evicted_key <= ev_next;
      occupancy   <= OCC_W'(count_next);
    end
  end

endmodule

/* hw/rtl/lot_cell.sv */
// One cell of the recency chain: a key register, its comparator and the match chain link.
module lot_cell (
  input  logic               clk,
  input  lot_pkg::cell_ctl_t ctl,
  input  lot_pkg::key_t      key_left,
  input  lot_pkg::key_t      key_cmp,
  input  logic               found_in,
  output lot_pkg::key_t      key_q,
  output logic               found_out
);
  import lot_pkg::*;

  key_t slot;

  // Shift the neighbor's key in when told to.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      slot <= key_left;
    end
  end

  // Extend the match chain: found_out is high when this or any more recent cell matches.
  always_comb begin
    found_out = found_in | (ctl.occupied & (slot == key_cmp));
  end

  assign key_q = slot;

endmodule

/* hw/rtl/lot_checker.sv */
// Port-level checks for the LRU order tracker, bound to the top level.
module lot_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          ok,
  input logic signed [lot_pkg::IN_KEY_W-1:0] evicted_key,
  input logic [lot_pkg::OCC_W-1:0]     occupancy
);
  import lot_pkg::*;

  // A stalled result word holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(evicted_key)
      && $stable(occupancy))
    else $error("result word changed while stalled");

  // A nonzero evicted key only comes with a successful operation.
  a_ev_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (evicted_key != '0) |-> ok)
    else $error("evicted key without ok");

  // Occupancy never exceeds the capacity.
  a_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occupancy <= OCC_W'(ENTRIES)))
    else $error("occupancy above capacity");

  // An accepted word always produces a result in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted word");

endmodule

bind lru_order_tracker lot_checker u_lot_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .ok         (ok),
  .evicted_key(evicted_key),
  .occupancy  (occupancy)
);
